/* rtl/core/wcsd_pkg.sv */
package wcsd_pkg;

    localparam int MAX_BINS     = 1024;
    localparam int BIN_W        = $clog2(MAX_BINS);
    localparam int CORDIC_STEPS = 16;
    localparam int ROOT_STEPS   = 18;   // 36-bit radicand, two bits a step
    localparam int DIV_STEPS    = 31;   // 31-bit dividend m << 15
    localparam int ITER_W       = 5;
    localparam int NL_W         = (BIN_W + 1 > 11) ? BIN_W + 1 : 11;
    localparam int MEM_W        = 64;

    // RAM word layout
    localparam int F_PEAK  = 0;
    localparam int F_LAST  = 16;
    localparam int F_OLDER = 32;
    localparam int F_WHITE = 48;

    localparam logic [15:0] RST_BINS  = 16'd512;
    localparam logic [15:0] RST_RELAX = 16'd64880;
    localparam logic [15:0] RST_FLOOR = 16'd1;
    localparam logic signed [17:0] KINV_Q16 = 18'sd39797;

    typedef enum logic [1:0] {
        CFG_BINS  = 2'd0,
        CFG_RELAX = 2'd1,
        CFG_FLOOR = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ_A,
        S_SQ_B,
        S_ROOT_A,
        S_VEC_INIT,
        S_VEC,
        S_PEAK,
        S_DIV_INIT,
        S_DIV,
        S_ROT_INIT,
        S_ROT,
        S_DIST,
        S_SQ_C,
        S_SQ_D,
        S_ROOT_B,
        S_DONE
    } t_state;

    // arctangent of 2^-i in 2^-16 turn
    function automatic logic [15:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd8192;
            5'd1:    v = 16'd4836;
            5'd2:    v = 16'd2555;
            5'd3:    v = 16'd1297;
            5'd4:    v = 16'd651;
            5'd5:    v = 16'd326;
            5'd6:    v = 16'd163;
            5'd7:    v = 16'd81;
            5'd8:    v = 16'd41;
            5'd9:    v = 16'd20;
            5'd10:   v = 16'd10;
            5'd11:   v = 16'd5;
            5'd12:   v = 16'd3;
            5'd13:   v = 16'd1;
            5'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/wcsd_ram.sv */
module wcsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/whitened_complex_spectral_difference.sv */
// Whitened complex spectral difference onset detector. Each input transaction
// carries one FFT bin; an internal counter walks the bins of a frame and, after
// bins_in_use bins, one output transaction carries the saturating frame sum.
// Per bin the magnitude is whitened against a relaxing, floored peak tracker,
// the phase is predicted by second difference, and the distance between last
// frame's whitened value and this one rotated by the phase deviation is summed.
// All arithmetic runs through one shared 18x18 multiplier, one bit-serial
// square root, one restoring divider and one CORDIC, stepped by a sequencer.
// Per bin the sequencer runs 2 squares, 18 root steps, 16 vectoring steps, 31
// divide steps, 16 rotation steps, 2 squares and 18 root steps, with setup and
// write-back states between them, then returns to the idle state in which the
// next bin is taken; s_axis_tready is high only between bins. A frame result
// waits in an output register, so the next bin is taken meanwhile; only a
// second frame end while that result is still unread stalls the last bin
// until the output transaction completes.
// After reset the per-bin RAM is cleared, one entry a cycle, all MAX_BINS
// (1024) entries before the first bin is accepted; configuration writes are
// accepted at all times.
module whitened_complex_spectral_difference
    import wcsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] bin_real, [31:16] bin_imag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [25:0] onset_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_bins;
    logic [15:0] r_relax;
    logic [15:0] r_floor;

    // frame control
    logic [BIN_W-1:0] r_bin;
    logic [BIN_W-1:0] r_clr;
    logic [25:0]      r_sum;
    logic [25:0]      r_out;
    logic             r_ovalid;

    // per-bin working registers
    logic signed [15:0] r_re, r_im;
    logic [MEM_W-1:0]   r_mem;
    logic [15:0]        r_m, r_ph, r_p2, r_w;
    logic signed [17:0] r_dx, r_ry;
    logic [ITER_W-1:0]  r_it;

    // square root unit
    logic [35:0] r_sq;
    logic [17:0] r_root;
    logic [21:0] r_rem;

    // divider
    logic [30:0] r_dvd;
    logic [15:0] r_drem;
    logic [15:0] r_quo;

    // CORDIC
    logic signed [35:0] r_cx, r_cy;
    logic signed [17:0] r_cz;

    // shared multiplier
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;

    logic             accept;
    logic             ram_we, ram_re;
    logic [BIN_W-1:0] ram_waddr;
    logic [MEM_W-1:0] ram_wdata, ram_rdata;
    logic             frame_end, can_finish;
    logic [BIN_W:0]   bin_next;
    logic [NL_W-1:0]  n_lim;
    logic             last_it;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign prod        = mul_a * mul_b;

    wcsd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_bin),
        .o_rdata (ram_rdata)
    );

    // frame length, zero read as one, clamped to the RAM depth
    always_comb begin
        if (r_bins == 11'd0) begin
            n_lim = NL_W'(1);
        end else if (NL_W'(r_bins) > NL_W'(MAX_BINS)) begin
            n_lim = NL_W'(MAX_BINS);
        end else begin
            n_lim = NL_W'(r_bins);
        end
    end

    assign bin_next   = {1'b0, r_bin} + 1'b1;
    assign frame_end  = NL_W'(bin_next) >= n_lim;
    assign can_finish = !(frame_end && r_ovalid && !m_axis_tready);

    // square root step: two radicand bits in, one root bit out
    logic [21:0] rt_rem_sh, rt_trial;
    assign rt_rem_sh = {r_rem[19:0], r_sq[35:34]};
    assign rt_trial  = {2'b00, r_root, 2'b01};

    // divider step
    logic [16:0] dv_rem_sh;
    assign dv_rem_sh = {r_drem, r_dvd[30]};

    // CORDIC shifted terms
    logic signed [35:0] cx_sh, cy_sh;
    logic signed [17:0] at;
    assign cx_sh = r_cx >>> r_it;
    assign cy_sh = r_cy >>> r_it;
    assign at    = 18'(atan_turn(r_it));

    // phase deviation, wrapped to a signed 16-bit angle
    logic signed [15:0] dev;
    assign dev = r_ph - {r_mem[F_LAST+14:F_LAST], 1'b0} + r_mem[F_OLDER+15:F_OLDER];

    // peak before floor
    logic [15:0] peak;
    assign peak = r_mem[F_PEAK+15:F_PEAK];

    logic [15:0] fl;
    assign fl = (r_floor == 16'd0) ? 16'd1 : r_floor;

    // rounding of the rotated vector back to Q1.15
    logic signed [35:0] rx_full, ry_full;
    assign rx_full = (r_cx + 36'sd32768) >>> 16;
    assign ry_full = (r_cy + 36'sd32768) >>> 16;

    logic [26:0] sum_add;
    assign sum_add = {1'b0, r_sum} + 27'(r_root);

    always_comb begin
        case (r_state)
            S_ROOT_A, S_ROOT_B: last_it = r_it == ITER_W'(ROOT_STEPS - 1);
            S_VEC, S_ROT:       last_it = r_it == ITER_W'(CORDIC_STEPS - 1);
            S_DIV:              last_it = r_it == ITER_W'(DIV_STEPS - 1);
            default:            last_it = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (&r_clr) n_state = S_IDLE;
            S_IDLE:     if (accept) n_state = S_SQ_A;
            S_SQ_A:     n_state = S_SQ_B;
            S_SQ_B:     n_state = S_ROOT_A;
            S_ROOT_A:   if (last_it) n_state = S_VEC_INIT;
            S_VEC_INIT: n_state = S_VEC;
            S_VEC:      if (last_it) n_state = S_PEAK;
            S_PEAK:     n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:      if (last_it) n_state = S_ROT_INIT;
            S_ROT_INIT: n_state = S_ROT;
            S_ROT:      if (last_it) n_state = S_DIST;
            S_DIST:     n_state = S_SQ_C;
            S_SQ_C:     n_state = S_SQ_D;
            S_SQ_D:     n_state = S_ROOT_B;
            S_ROOT_B:   if (last_it) n_state = S_DONE;
            S_DONE:     if (can_finish) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // outputs: handshake, RAM port, multiplier operands
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = r_bin;
        ram_wdata     = {r_w, r_mem[F_LAST+15:F_LAST], r_ph, r_p2};
        mul_a         = 18'sd0;
        mul_b         = 18'sd0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                ram_re        = 1'b1;
            end
            S_SQ_A: begin
                mul_a = 18'(r_re);
                mul_b = 18'(r_re);
            end
            S_SQ_B: begin
                mul_a = 18'(r_im);
                mul_b = 18'(r_im);
            end
            S_PEAK: begin
                mul_a = {2'b00, peak - r_m};
                mul_b = {2'b00, r_relax};
            end
            S_ROT_INIT: begin
                mul_a = {2'b00, r_quo};
                mul_b = KINV_Q16;
            end
            S_SQ_C: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            S_SQ_D: begin
                mul_a = r_ry;
                mul_b = r_ry;
            end
            S_DONE: begin
                ram_we = can_finish;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_bin    <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_bins   <= 11'(RST_BINS);
            r_relax  <= RST_RELAX;
            r_floor  <= RST_FLOOR;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BINS:  r_bins  <= i_cfg_data[10:0];
                    CFG_RELAX: r_relax <= i_cfg_data;
                    CFG_FLOOR: r_floor <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (r_state == S_DONE && can_finish) begin
                if (frame_end) begin
                    r_out    <= sum_add[26] ? 26'h3FFFFFF : sum_add[25:0];
                    r_ovalid <= 1'b1;
                    r_sum    <= '0;
                    r_bin    <= '0;
                end else begin
                    r_sum <= sum_add[26] ? 26'h3FFFFFF : sum_add[25:0];
                    r_bin <= bin_next[BIN_W-1:0];
                end
            end
            // a new frame result in the same cycle keeps the register full
            if (m_axis_tvalid && m_axis_tready
                && !(r_state == S_DONE && can_finish && frame_end)) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_re <= signed'(s_axis_tdata[15:0]);
                r_im <= signed'(s_axis_tdata[31:16]);
            end
            S_SQ_A: begin
                r_mem <= ram_rdata;
                r_sq  <= unsigned'(prod);
            end
            S_SQ_B, S_SQ_D: begin
                r_sq   <= r_sq + unsigned'(prod);
                r_root <= '0;
                r_rem  <= '0;
                r_it   <= '0;
            end
            S_ROOT_A, S_ROOT_B: begin
                r_sq <= {r_sq[33:0], 2'b00};
                r_it <= r_it + 1'b1;
                if (rt_rem_sh >= rt_trial) begin
                    r_rem  <= rt_rem_sh - rt_trial;
                    r_root <= {r_root[16:0], 1'b1};
                end else begin
                    r_rem  <= rt_rem_sh;
                    r_root <= {r_root[16:0], 1'b0};
                end
            end
            S_VEC_INIT: begin
                r_m  <= r_root[15:0];
                r_it <= '0;
                // left half-plane: turn by a half turn first
                if (r_re < 0) begin
                    r_cx <= -36'(r_re);
                    r_cy <= -36'(r_im);
                    r_cz <= 18'sd32768;
                end else begin
                    r_cx <= 36'(r_re);
                    r_cy <= 36'(r_im);
                    r_cz <= '0;
                end
            end
            S_VEC: begin
                r_it <= r_it + 1'b1;
                if (!r_cy[35]) begin
                    r_cx <= r_cx + cy_sh;
                    r_cy <= r_cy - cx_sh;
                    r_cz <= r_cz + at;
                end else begin
                    r_cx <= r_cx - cy_sh;
                    r_cy <= r_cy + cx_sh;
                    r_cz <= r_cz - at;
                end
            end
            S_PEAK: begin
                // zero bin has phase zero
                r_ph <= (r_re == 16'sd0 && r_im == 16'sd0) ? 16'd0 : r_cz[15:0];
                r_p2 <= (r_m < peak) ? r_m + prod[31:16] : r_m;
            end
            S_DIV_INIT: begin
                r_p2   <= (r_p2 < fl) ? fl : r_p2;
                r_dvd  <= {r_m, 15'd0};
                r_drem <= '0;
                r_quo  <= '0;
                r_it   <= '0;
            end
            S_DIV: begin
                r_dvd <= {r_dvd[29:0], 1'b0};
                r_it  <= r_it + 1'b1;
                if (dv_rem_sh >= {1'b0, r_p2}) begin
                    r_drem <= 16'(dv_rem_sh - {1'b0, r_p2});
                    r_quo  <= {r_quo[14:0], 1'b1};
                end else begin
                    r_drem <= dv_rem_sh[15:0];
                    r_quo  <= {r_quo[14:0], 1'b0};
                end
            end
            S_ROT_INIT: begin
                r_w  <= r_quo;
                r_it <= '0;
                r_cy <= '0;
                // beyond a quarter turn: pre-rotate by a half turn
                if (dev > 16'sd16384) begin
                    r_cx <= -prod;
                    r_cz <= 18'(dev) - 18'sd32768;
                end else if (dev < -16'sd16384) begin
                    r_cx <= -prod;
                    r_cz <= 18'(dev) + 18'sd32768;
                end else begin
                    r_cx <= prod;
                    r_cz <= 18'(dev);
                end
            end
            S_ROT: begin
                r_it <= r_it + 1'b1;
                if (!r_cz[17]) begin
                    r_cx <= r_cx - cy_sh;
                    r_cy <= r_cy + cx_sh;
                    r_cz <= r_cz - at;
                end else begin
                    r_cx <= r_cx + cy_sh;
                    r_cy <= r_cy - cx_sh;
                    r_cz <= r_cz + at;
                end
            end
            S_DIST: begin
                r_dx <= signed'({2'b00, r_mem[F_WHITE+15:F_WHITE]}) - 18'(rx_full);
                r_ry <= 18'(ry_full);
            end
            S_SQ_C: begin
                r_sq <= unsigned'(prod);
            end
            default: begin
                r_it <= r_it;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule
